### hw/rtl/assert_macros.svh
// Assertion macros shared by the curve unit RTL.
// Depends on nothing; each macro wraps one clocked concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/pcl_pkg.sv
// Shared types, sizes and codes for the piecewise linear curve unit.
// Depends on nothing; used by pcl_ctrl, pcl_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package pcl_pkg;

  localparam int VW         = 16;
  localparam int MAX_POINTS = 16;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CNTW       = $clog2(MAX_POINTS + 1);
  localparam int PCW        = 5;
  localparam int DCW        = $clog2(VW);

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_FWD   = 2'd2;
  localparam logic [1:0] OP_INV   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MONO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]           operation;
    logic signed [VW-1:0] point_x;
    logic signed [VW-1:0] point_y;
    logic signed [VW-1:0] query;
  } in_word_t;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic [1:0]           status;
    logic [PCW-1:0]       point_count;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic set_full;
    logic find_step;
    logic set_pos;
    logic chk_step;
    logic set_mono;
    logic commit;
    logic res_single;
    logic walk_step;
    logic res_prev;
    logic res_cur;
    logic seg_load;
    logic mul;
    logic div_step;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic count_zero;
    logic count_one;
    logic full;
    logic find_go;
    logic chk_bad;
    logic chk_last;
    logic walk_first;
    logic walk_second;
    logic reach_prev;
    logic reach_cur;
    logic key_eq;
    logic walk_last;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

### hw/rtl/pcl_dp.sv
// Datapath of the curve unit: point table, walk registers, multiplier and divider.
// Depends on pcl_pkg and assert_macros.svh; driven by pcl_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pcl_dp (
  input  wire               clk,
  input  wire               rst,
  input  wire pcl_pkg::in_word_t item,
  input  wire pcl_pkg::cmd_t     cmd,
  output pcl_pkg::sts_t     sts,
  output pcl_pkg::out_word_t result
);
  import pcl_pkg::*;

  logic [1:0]           op;
  logic signed [VW-1:0] px, py, qv;
  logic signed [VW-1:0] x_mem [MAX_POINTS];
  logic signed [VW-1:0] y_mem [MAX_POINTS];
  logic [CNTW-1:0]      count, idx, pos;
  logic signed [VW-1:0] prev_k, prev_v;
  logic                 dir;
  logic signed [VW-1:0] res_value;
  logic [1:0]           res_status;
  logic signed [VW-1:0] b0;
  logic                 neg;
  logic [VW-1:0]        mag_num, mag_dq, den;
  logic [VW-1:0]        rem, quo;
  logic [DCW-1:0]       dcnt;

  logic [CNTW-1:0]      addr_full;
  logic [AW-1:0]        raddr;
  logic signed [VW-1:0] rd_x, rd_y, ty, key, val;
  logic                 use_x, chk_dir, w_dir;
  logic signed [VW:0]   num, dq, dd;
  logic [2*VW-1:0]      prod;
  logic [VW:0]          trial;
  logic                 ge;

  function automatic logic [VW-1:0] mag(input logic signed [VW:0] v);
    logic signed [VW:0] a;
    a = v[VW] ? -v : v;
    return a[VW-1:0];
  endfunction

  // Entries past the insert point read one slot lower while checking.
  always_comb begin
    addr_full = (idx > pos) ? idx - CNTW'(1) : idx;
    raddr     = addr_full[AW-1:0];
    rd_x      = x_mem[raddr];
    rd_y      = y_mem[raddr];
    ty        = (idx == pos) ? py : rd_y;
    use_x     = (op == OP_FWD);
    key       = use_x ? rd_x : rd_y;
    val       = use_x ? rd_y : rd_x;
    chk_dir   = (idx == CNTW'(1)) ? (ty >= prev_k) : dir;
    w_dir     = (idx == CNTW'(1)) ? (use_x || (key >= prev_k)) : dir;
    num       = {val[VW-1], val} - {prev_v[VW-1], prev_v};
    dq        = {qv[VW-1], qv} - {prev_k[VW-1], prev_k};
    dd        = {key[VW-1], key} - {prev_k[VW-1], prev_k};
    prod      = mag_num * mag_dq;
    trial     = {rem, quo[VW-1]};
    ge        = trial >= {1'b0, den};
  end

  always_comb begin
    sts.op          = op;
    sts.count_zero  = (count == '0);
    sts.count_one   = (count == CNTW'(1));
    sts.full        = (count >= CNTW'(MAX_POINTS));
    sts.find_go     = (idx < count) && (rd_x < px);
    sts.chk_bad     = (idx != '0) && (chk_dir ? (ty <= prev_k) : (ty >= prev_k));
    sts.chk_last    = (idx == count);
    sts.walk_first  = (idx == '0);
    sts.walk_second = (idx == CNTW'(1));
    sts.reach_prev  = w_dir ? (prev_k >= qv) : (prev_k <= qv);
    sts.reach_cur   = w_dir ? (key >= qv) : (key <= qv);
    sts.key_eq      = (key == qv);
    sts.walk_last   = (idx == count - CNTW'(1));
    sts.div_last    = (dcnt == DCW'(VW - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count + CNTW'(1);
    end
  end

  // Insert: shift entries at and above the slot up by one, drop the new point in.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (pos == '0) begin
        x_mem[0] <= px;
        y_mem[0] <= py;
      end
      for (int e = 1; e < MAX_POINTS; e++) begin
        if (CNTW'(e) == pos) begin
          x_mem[e] <= px;
          y_mem[e] <= py;
        end else if (CNTW'(e) > pos) begin
          x_mem[e] <= x_mem[e-1];
          y_mem[e] <= y_mem[e-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= item.operation;
      px         <= item.point_x;
      py         <= item.point_y;
      qv         <= item.query;
      idx        <= '0;
      pos        <= '1;
      res_value  <= '0;
      res_status <= ST_OK;
    end
    if (cmd.set_full) res_status <= ST_FULL;
    if (cmd.set_mono) res_status <= ST_MONO;
    if (cmd.find_step) idx <= idx + CNTW'(1);
    if (cmd.set_pos) begin
      pos <= idx;
      idx <= '0;
    end
    if (cmd.chk_step) begin
      prev_k <= ty;
      if (idx == CNTW'(1)) dir <= chk_dir;
      idx <= idx + CNTW'(1);
    end
    if (cmd.walk_step) begin
      prev_k <= key;
      prev_v <= val;
      if (idx == CNTW'(1)) dir <= w_dir;
      idx <= idx + CNTW'(1);
    end
    if (cmd.res_single) res_value <= val;
    if (cmd.res_prev) res_value <= prev_v;
    if (cmd.res_cur) res_value <= val;
    if (cmd.seg_load) begin
      b0      <= prev_v;
      neg     <= num[VW] ^ dq[VW] ^ dd[VW];
      mag_num <= mag(num);
      mag_dq  <= mag(dq);
      den     <= mag(dd);
    end
    if (cmd.mul) begin
      rem  <= prod[2*VW-1:VW];
      quo  <= prod[VW-1:0];
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? VW'(trial - {1'b0, den}) : trial[VW-1:0];
      quo  <= {quo[VW-2:0], ge};
      dcnt <= dcnt + DCW'(1);
    end
    if (cmd.fin) res_value <= b0 + (neg ? (~quo + VW'(1)) : quo);
    if (cmd.out_load) begin
      result.value       <= res_value;
      result.status      <= res_status;
      result.point_count <= PCW'(count);
    end
  end

  `ASSERT_ALWAYS(a_count_max, clk, rst, count <= CNTW'(MAX_POINTS), "point count above table size")
  `ASSERT_IMPL(a_commit_room, clk, rst, cmd.commit, count < CNTW'(MAX_POINTS), "insert into full table")

endmodule
`default_nettype wire

### hw/rtl/pcl_ctrl.sv
// Sequencer of the curve unit: input/output handshake and per-operation steps.
// Depends on pcl_pkg and assert_macros.svh; commands pcl_dp.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pcl_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            item_valid,
  output logic           item_stall,
  output logic           result_valid,
  input  wire            result_stall,
  input  wire pcl_pkg::sts_t  sts,
  output pcl_pkg::cmd_t  cmd
);
  import pcl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_FIND   = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_COMMIT = 4'd4;
  localparam logic [3:0] S_WALK   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_FINAL  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_TIE    = 4'd10;

  logic [3:0] state, state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op)
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end
          OP_ADD: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
              state_next   = S_DONE;
            end else begin
              state_next = S_FIND;
            end
          end
          default: begin
            if (sts.count_zero) begin
              state_next = S_DONE;
            end else if (sts.count_one) begin
              cmd.res_single = 1'b1;
              state_next     = S_DONE;
            end else begin
              state_next = S_WALK;
            end
          end
        endcase
      end
      S_FIND: begin
        if (sts.find_go) begin
          cmd.find_step = 1'b1;
        end else begin
          cmd.set_pos = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.chk_bad) begin
          cmd.set_mono = 1'b1;
          state_next   = S_DONE;
        end else if (sts.chk_last) begin
          state_next = S_COMMIT;
        end else begin
          cmd.chk_step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_WALK: begin
        priority if (sts.walk_first) begin
          cmd.walk_step = 1'b1;
        end else if (sts.walk_second && sts.reach_prev) begin
          cmd.res_prev = 1'b1;
          state_next   = S_DONE;
        end else if (sts.reach_cur && !sts.key_eq) begin
          cmd.seg_load = 1'b1;
          state_next   = S_MUL;
        end else if (sts.reach_cur) begin
          // Exact hit on a key: take its value, then skip equal keys after it,
          // so that a run of equal keys ending on the last key gives the last point.
          cmd.res_cur = 1'b1;
          if (sts.walk_last) begin
            state_next = S_DONE;
          end else begin
            cmd.find_step = 1'b1;
            state_next    = S_TIE;
          end
        end else if (sts.walk_last) begin
          cmd.res_cur = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_TIE: begin
        priority if (!sts.key_eq) begin
          state_next = S_DONE;
        end else if (sts.walk_last) begin
          cmd.res_cur = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.find_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.fin    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_accept_disp, clk, rst, item_valid && !item_stall, state == S_DISP, "accepted word not dispatched")
  `ASSERT_IMPL(a_rise_from_done, clk, rst, $rose(result_valid), $past(state) == S_DONE, "result word without finish")
  `ASSERT_IMPL(a_final_after_div, clk, rst, state == S_FINAL, $past(state) == S_DIV, "final step out of order")

endmodule
`default_nettype wire

### hw/rtl/monotonic_piecewise_linear_curve_unit.sv
// Add walks the table twice (slot search, then monotonic check of the new order).
// Evaluation walks the table for the segment; a query between two keys then takes one multiply and a 16-step divide.
// One word is in work at a time; the next is taken the cycle after the result word is registered.
// Reset (rst, synchronous) empties the table and drops any pending result word.
`timescale 1ns / 1ps
`default_nettype none
module monotonic_piecewise_linear_curve_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_stall,
  input  wire pcl_pkg::in_word_t item,
  output logic               result_valid,
  input  wire                result_stall,
  output pcl_pkg::out_word_t result
);
  import pcl_pkg::*;

  // Command and status buses between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // Sequencer: handshake, and the step order for add, clear and both evaluations.
  pcl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Datapath: sorted point table, segment walk, multiply and restoring divide,
  // and the output word register that holds until the consumer takes it.
  // Table entries hold no reset value; only entries below the point count are read.
  pcl_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule
`default_nettype wire
